[src/bsc_pkg.sv]
package bsc_pkg;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_TDIV  = 2'd1;
  localparam logic [1:0] ERR_PDIV  = 2'd2;

  localparam logic [2:0] REG_COEF0 = 3'd0;
  localparam logic [2:0] REG_COEF1 = 3'd1;
  localparam logic [2:0] REG_COEF2 = 3'd2;
  localparam logic [2:0] REG_COEF3 = 3'd3;
  localparam logic [2:0] REG_COEF4 = 3'd4;
  localparam logic [2:0] REG_OSS   = 3'd5;

  localparam logic [31:0] T_OFFSET = 32'd4000;
  localparam logic [31:0] P_HALF   = 32'd32768;
  localparam logic [31:0] P_SCALE  = 32'd50000;
  localparam logic [31:0] P_C1     = 32'd3038;
  localparam logic [31:0] P_C2     = 32'd7357;
  localparam logic [31:0] P_C3     = 32'd3791;

  // One restoring-division step on unsigned operands
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s, logic [31:0] dvs);
    div_st_t     o;
    logic [32:0] trial;
    trial = {s.rem, s.quo[31]} - {1'b0, dvs};
    o.quo = {s.quo[30:0], ~trial[32]};
    o.rem = trial[32] ? {s.rem[30:0], s.quo[31]} : trial[31:0];
    return o;
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] v, int unsigned n);
    return 32'($signed(v) >>> n);
  endfunction

endpackage

[src/bsc_div.sv]
// Pipelined unsigned 32/32 divider, four quotient bits per stage, with
// side-band payload carried along. Stall freezes every stage.
module bsc_div
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_v,
  input  logic [31:0] dvd,
  input  logic [31:0] dvs,
  input  logic [95:0] side_in,
  output logic        out_v,
  output logic [31:0] quo,
  output logic [95:0] side_out
);

  localparam int unsigned NST = 8;

  div_st_t     st_r   [NST];
  logic [31:0] dvs_r  [NST];
  logic [95:0] side_r [NST];
  logic [NST-1:0] v_r;

  div_st_t st_nxt [NST];

  // Four division steps per stage
  always_comb begin
    div_st_t s;
    for (int k = 0; k < NST; k++) begin
      if (k == 0) begin
        s.rem = '0;
        s.quo = dvd;
      end else begin
        s = st_r[k-1];
      end
      for (int j = 0; j < 4; j++) begin
        s = div_step(s, (k == 0) ? dvs : dvs_r[k-1]);
      end
      st_nxt[k] = s;
    end
  end

  // Advance the stages together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        st_r[k]   <= st_nxt[k];
        dvs_r[k]  <= (k == 0) ? dvs : dvs_r[k-1];
        side_r[k] <= (k == 0) ? side_in : side_r[k-1];
      end
    end
  end

  assign out_v    = v_r[NST-1];
  assign quo      = st_r[NST-1].quo;
  assign side_out = side_r[NST-1];

endmodule

[src/barometric_sensor_compensation.sv]
// Barometric sensor compensation.
// Input channel in_*: tdata = {raw_pressure[39:16], raw_temperature[15:0]}.
// Output channel out_*: tdata = {pressure_pascal[47:16], temperature_tenths
// [15:0]}, tuser = error_code. Configuration channel cfg_*: cfg_index selects
// a coefficient word (0..4) or the oversampling setting (5); other indexes
// are dropped. Write configuration only while the block is empty.
// Throughput: one transfer per cycle while the output slot is not stalled. The
// pipeline runs through two 8-stage dividers (temperature and pressure),
// with multiply and shift stages before, between and after them.
// Reset: all pipeline valid bits clear, coefficients clear, oversampling
// reads 3. When the receiver stalls while the result register is full, the
// whole pipeline holds; the result register parts the sides so in_tready
// follows out_tready or an empty output slot.
module barometric_sensor_compensation
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // raw_temperature, raw_pressure
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // temperature_tenths, pressure_pascal
  output logic [1:0]  out_tuser,  // error_code
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] cw0_r, cw1_r, cw2_r, cw3_r, cw4_r;
  logic [1:0]  oss_r;

  assign cfg_ready = 1'b1;

  // Hold the coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw0_r <= '0; cw1_r <= '0; cw2_r <= '0; cw3_r <= '0; cw4_r <= '0;
      oss_r <= 2'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COEF0: cw0_r <= cfg_data;
        REG_COEF1: cw1_r <= cfg_data;
        REG_COEF2: cw2_r <= cfg_data;
        REG_COEF3: cw3_r <= cfg_data;
        REG_COEF4: cw4_r <= cfg_data;
        REG_OSS:   oss_r <= cfg_data[1:0];
        default:   ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = 32'($signed(cw0_r[31:16]));
  assign ac2 = 32'($signed(cw0_r[15:0]));
  assign ac3 = 32'($signed(cw1_r[31:16]));
  assign ac4 = {16'd0, cw1_r[15:0]};
  assign ac5 = {16'd0, cw2_r[31:16]};
  assign ac6 = {16'd0, cw2_r[15:0]};
  assign b1  = 32'($signed(cw3_r[31:16]));
  assign b2  = 32'($signed(cw3_r[15:0]));
  assign mc  = 32'($signed(cw4_r[31:16]));
  assign md  = 32'($signed(cw4_r[15:0]));

  // Global advance: hold everything while the output slot is full and stalled
  logic adv;
  logic ov_r;
  assign adv = !ov_r || out_tready;
  assign in_tready = adv;

  // Stage A: temperature product and shifted raw pressure
  logic        a_v_r;
  logic [31:0] a_prod_r, a_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_prod_r <= ({16'd0, in_tdata[15:0]} - ac6) * ac5;
      a_up_r   <= {8'd0, in_tdata[39:16]} >> (4'd8 - {2'd0, oss_r});
    end
  end

  // Stage B: x1, denominator and signed operand magnitudes
  logic        b_v_r;
  logic [31:0] b_x1_r, b_ma_r, b_mb_r, b_up_r;
  logic        b_neg_r, b_zero_r;
  logic [31:0] x1_b, den_b, num_b;
  always_comb begin
    x1_b  = asr32(a_prod_r, 15);
    den_b = x1_b + md;
    num_b = mc << 11;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (adv) b_v_r <= a_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_x1_r   <= x1_b;
      b_ma_r   <= num_b[31] ? -num_b : num_b;
      b_mb_r   <= den_b[31] ? -den_b : den_b;
      b_neg_r  <= num_b[31] ^ den_b[31];
      b_zero_r <= (den_b == '0);
      b_up_r   <= a_up_r;
    end
  end

  // Temperature divider
  logic        td_v;
  logic [31:0] td_q;
  logic [95:0] td_side;
  bsc_div u_tdiv (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(b_v_r),
    .dvd(b_ma_r), .dvs(b_zero_r ? 32'd1 : b_mb_r),
    .side_in({b_up_r, b_x1_r, 30'd0, b_neg_r, b_zero_r}),
    .out_v(td_v), .quo(td_q), .side_out(td_side)
  );

  // Stage C: b5, b6, temperature
  logic        c_v_r, c_zero_r;
  logic [31:0] c_b6_r, c_up_r;
  logic [15:0] c_t_r;
  logic [31:0] x2_c, b5_c;
  always_comb begin
    x2_c = td_side[1] ? -td_q : td_q;
    b5_c = td_side[63:32] + x2_c;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (adv) c_v_r <= td_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_zero_r <= td_side[0];
      c_b6_r   <= b5_c - T_OFFSET;
      c_t_r    <= 16'(asr32(b5_c + 32'd8, 4));
      c_up_r   <= td_side[95:64];
    end
  end

  // Stage D: b6 squared and linear products
  logic        d_v_r, d_zero_r;
  logic [31:0] d_sq_r, d_ac2b6_r, d_ac3b6_r, d_up_r;
  logic [15:0] d_t_r;
  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (adv) d_v_r <= c_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d_zero_r  <= c_zero_r;
      d_t_r     <= c_t_r;
      d_sq_r    <= c_b6_r * c_b6_r;
      d_ac2b6_r <= ac2 * c_b6_r;
      d_ac3b6_r <= ac3 * c_b6_r;
      d_up_r    <= c_up_r;
    end
  end

  // Stage E: quadratic products
  logic        e_v_r, e_zero_r;
  logic [31:0] e_b2sq_r, e_b1sq_r, e_x2a_r, e_x1b_r, e_up_r;
  logic [15:0] e_t_r;
  logic [31:0] sq_e;
  assign sq_e = asr32(d_sq_r, 12);
  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (adv) e_v_r <= d_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      e_zero_r <= d_zero_r;
      e_t_r    <= d_t_r;
      e_b2sq_r <= b2 * sq_e;
      e_b1sq_r <= b1 * sq_e;
      e_x2a_r  <= asr32(d_ac2b6_r, 11);
      e_x1b_r  <= asr32(d_ac3b6_r, 13);
      e_up_r   <= d_up_r;
    end
  end

  // Stage F: b3 and x3 for b4
  logic        f_v_r, f_zero_r;
  logic [31:0] f_b3_r, f_x3_r, f_up_r;
  logic [15:0] f_t_r;
  logic [31:0] x3a_f, x3b_f;
  always_comb begin
    x3a_f = asr32(e_b2sq_r, 11) + e_x2a_r;
    x3b_f = asr32(e_x1b_r + asr32(e_b1sq_r, 16) + 32'd2, 2);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else if (adv) f_v_r <= e_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f_zero_r <= e_zero_r;
      f_t_r    <= e_t_r;
      f_b3_r   <= asr32(((ac1 * 32'd4 + x3a_f) << oss_r) + 32'd2, 2);
      f_x3_r   <= x3b_f + P_HALF;
      f_up_r   <= e_up_r;
    end
  end

  // Stage G: b4 and b7 products
  logic        g_v_r, g_zero_r;
  logic [31:0] g_b4p_r, g_b7_r;
  logic [15:0] g_t_r;
  always_ff @(posedge clk) begin
    if (!rst_n) g_v_r <= 1'b0;
    else if (adv) g_v_r <= f_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      g_zero_r <= f_zero_r;
      g_t_r    <= f_t_r;
      g_b4p_r  <= ac4 * f_x3_r;
      g_b7_r   <= (f_up_r - f_b3_r) * (P_SCALE >> oss_r);
    end
  end

  // Pressure divider: b7 < 2^31 divides 2*b7, else b7 with quotient doubled
  logic [31:0] b4_g;
  logic        b4z_g;
  assign b4_g  = g_b4p_r >> 15;
  assign b4z_g = (b4_g == '0);

  logic        pd_v;
  logic [31:0] pd_q;
  logic [95:0] pd_side;
  bsc_div u_pdiv (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(g_v_r),
    .dvd(g_b7_r[31] ? g_b7_r : (g_b7_r << 1)),
    .dvs(b4z_g ? 32'd1 : b4_g),
    .side_in({60'd0, g_t_r, 16'd0, 1'b0, g_b7_r[31], b4z_g, g_zero_r}),
    .out_v(pd_v), .quo(pd_q), .side_out(pd_side)
  );

  // Stage H: pressure and its shifted copy
  logic        h_v_r, h_tz_r, h_pz_r;
  logic [31:0] h_p_r, h_ps_r;
  logic [15:0] h_t_r;
  logic [31:0] p_h;
  assign p_h = pd_side[2] ? (pd_q << 1) : pd_q;
  always_ff @(posedge clk) begin
    if (!rst_n) h_v_r <= 1'b0;
    else if (adv) h_v_r <= pd_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      h_tz_r <= pd_side[0];
      h_pz_r <= pd_side[1];
      h_t_r  <= pd_side[35:20];
      h_p_r  <= p_h;
      h_ps_r <= asr32(p_h, 8);
    end
  end

  // Stage I: square of the shifted pressure and the linear product
  logic        i_v_r, i_tz_r, i_pz_r;
  logic [31:0] i_p_r, i_sq_r, i_lin_r;
  logic [15:0] i_t_r;
  always_ff @(posedge clk) begin
    if (!rst_n) i_v_r <= 1'b0;
    else if (adv) i_v_r <= h_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      i_tz_r  <= h_tz_r;
      i_pz_r  <= h_pz_r;
      i_t_r   <= h_t_r;
      i_p_r   <= h_p_r;
      i_sq_r  <= h_ps_r * h_ps_r;
      i_lin_r <= h_p_r * (32'd0 - P_C2);
    end
  end

  // Stage J: times 3038
  logic        j_v_r, j_tz_r, j_pz_r;
  logic [31:0] j_p_r, j_q_r, j_lin_r;
  logic [15:0] j_t_r;
  always_ff @(posedge clk) begin
    if (!rst_n) j_v_r <= 1'b0;
    else if (adv) j_v_r <= i_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      j_tz_r  <= i_tz_r;
      j_pz_r  <= i_pz_r;
      j_t_r   <= i_t_r;
      j_p_r   <= i_p_r;
      j_q_r   <= i_sq_r * P_C1;
      j_lin_r <= i_lin_r;
    end
  end

  // Output register
  logic [31:0] p_fin;
  logic [47:0] od_r;
  logic [1:0]  ou_r;
  assign p_fin = j_p_r + asr32(asr32(j_q_r, 16) + asr32(j_lin_r, 16) + P_C3, 4);

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= j_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (j_tz_r) begin
        od_r <= '0;
        ou_r <= ERR_TDIV;
      end else if (j_pz_r) begin
        od_r <= {32'd0, j_t_r};
        ou_r <= ERR_PDIV;
      end else begin
        od_r <= {p_fin, j_t_r};
        ou_r <= ERR_OK;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  // A stalled result holds until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // Input is refused only while the result slot is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input refused without stall");

  // A temperature divisor fault clears the payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ERR_TDIV |-> out_tdata == '0)
    else $error("nonzero payload on temperature fault");

  // A pressure divisor fault clears the pressure
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ERR_PDIV |-> out_tdata[47:16] == '0)
    else $error("nonzero pressure on pressure fault");

endmodule

[test/barometric_sensor_compensation_tb.sv]
`timescale 1ns / 100ps

module barometric_sensor_compensation_tb;
  import bsc_pkg::*;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [23:0] raw_press;
  } reading_t;

  typedef struct packed {
    logic [15:0] temp_tenths;
    logic [31:0] press_pa;
    logic [1:0]  err;
  } comp_t;

  // Directed row: reading, optional fixed expectation
  typedef struct packed {
    reading_t rd;
    logic     fixed;
    comp_t    res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // raw_temperature[15:0], raw_pressure[39:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // temperature_tenths[15:0], pressure_pascal[47:16]
  logic [1:0]  out_tuser;   // error_code
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Calibration copy for the predictor
  logic [31:0] coef [0:4];
  logic [1:0]  oss_q;

  comp_t comp_queue[$];
  int    fail_cnt;
  bit    quiet;

  barometric_sensor_compensation i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [31:0] sar(logic [31:0] v, int n);
    return $signed(v) >>> n;
  endfunction

  function automatic logic [31:0] sext(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Signed quotient truncated toward zero, wrapping on overflow
  function automatic logic [31:0] quot_s(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic comp_t compensate(reading_t rd);
    comp_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
    ac1 = sext(coef[0][31:16]); ac2 = sext(coef[0][15:0]);
    ac3 = sext(coef[1][31:16]); ac4 = {16'd0, coef[1][15:0]};
    ac5 = {16'd0, coef[2][31:16]}; ac6 = {16'd0, coef[2][15:0]};
    b1 = sext(coef[3][31:16]); b2 = sext(coef[3][15:0]);
    mc = sext(coef[4][31:16]); md = sext(coef[4][15:0]);
    ut = {16'd0, rd.raw_temp};
    up = {8'd0, rd.raw_press} >> (8 - oss_q);
    r = '0;
    x1 = sar((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.err = ERR_TDIV;
      return r;
    end
    x2 = quot_s(mc << 11, den);
    b5 = x1 + x2;
    x3 = sar(b5 + 8, 4);
    r.temp_tenths = x3[15:0];
    b6 = b5 - T_OFFSET;
    sq = sar(b6 * b6, 12);
    x1 = sar(b2 * sq, 11);
    x2 = sar(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sar(((ac1 * 4 + x3) << oss_q) + 2, 2);
    x1 = sar(ac3 * b6, 13);
    x2 = sar(b1 * sq, 16);
    x3 = sar(x1 + x2 + 2, 2);
    b4 = (ac4 * (x3 + P_HALF)) >> 15;
    b7 = (up - b3) * (P_SCALE >> oss_q);
    if (b4 == 0) begin
      r.err = ERR_PDIV;
      return r;
    end
    if (!b7[31]) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = sar(sar(p, 8) * sar(p, 8) * P_C1, 16);
    x2 = sar(p * (-P_C2), 16);
    p = p + sar(x1 + x2 + P_C3, 4);
    r.press_pa = p;
    r.err = ERR_OK;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx <= REG_COEF4) coef[idx] = val;
    else if (idx == REG_OSS) oss_q = val[1:0];
  endtask

  // Random gap before a transfer, none in quiet mode
  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_reading(reading_t rd, logic fixed, comp_t res);
    maybe_gap();
    in_tvalid <= 1'b1;
    in_tdata <= {rd.raw_press, rd.raw_temp};
    comp_queue.push_back(fixed ? res : compensate(rd));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (comp_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    comp_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[47:16], out_tuser};
      if (comp_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_cnt++;
      end else begin
        want = comp_queue.pop_front();
        if (got.temp_tenths !== want.temp_tenths) begin
          $display("%0t: temperature expected %h actual %h", $time,
                   want.temp_tenths, got.temp_tenths);
          fail_cnt++;
        end
        if (got.press_pa !== want.press_pa) begin
          $display("%0t: pressure expected %h actual %h", $time,
                   want.press_pa, got.press_pa);
          fail_cnt++;
        end
        if (got.err !== want.err) begin
          $display("%0t: error code expected %h actual %h", $time,
                   want.err, got.err);
          fail_cnt++;
        end
      end
    end
  end

  // Receiver stalls in random bursts
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Typical calibration set
  task automatic load_typical();
    write_reg(REG_COEF0, {16'sd408, -16'sd72});
    write_reg(REG_COEF1, {-16'sd14383, 16'd32741});
    write_reg(REG_COEF2, {16'd32757, 16'd23153});
    write_reg(REG_COEF3, {16'sd6190, 16'sd4});
    write_reg(REG_COEF4, {-16'sd8711, 16'sd2868});
  endtask

  initial begin
    row_t rows [$];
    reading_t rd;
    fail_cnt = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < 5; i++) coef[i] = '0;
    oss_q = 2'd3;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset all coefficients are zero: divisor x1+md is zero
    rows.push_back('{'{16'd0, 24'd0}, 1'b1, '{16'd0, 32'd0, ERR_TDIV}});
    rows.push_back('{'{16'hFFFF, 24'hFFFFFF}, 1'b1, '{16'd0, 32'd0, ERR_TDIV}});
    foreach (rows[i]) send_reading(rows[i].rd, rows[i].fixed, rows[i].res);
    drain();

    // Typical calibration, extremes and the usual readings
    load_typical();
    rows.delete();
    rows.push_back('{'{16'd27898, 24'd23843 << 8}, 1'b0, '0});
    rows.push_back('{'{16'd0, 24'd0}, 1'b0, '0});
    rows.push_back('{'{16'hFFFF, 24'hFFFFFF}, 1'b0, '0});
    rows.push_back('{'{16'h8000, 24'h800000}, 1'b0, '0});
    rows.push_back('{'{16'h7FFF, 24'h7FFFFF}, 1'b0, '0});
    rows.push_back('{'{16'd23153, 24'h5A5A5A}, 1'b0, '0});
    foreach (rows[i]) send_reading(rows[i].rd, rows[i].fixed, rows[i].res);
    drain();
    // Oversampling extremes
    write_reg(REG_OSS, 32'hFFFF_FFFC);
    send_reading('{16'd27898, 24'h5D2300}, 1'b0, '0);
    send_reading('{16'hFFFF, 24'hFFFFFF}, 1'b0, '0);
    drain();
    // Unused index is dropped
    write_reg(3'd7, 32'hDEAD_BEEF);
    // Zero divisor scale forces the pressure divisor error
    write_reg(REG_COEF1, 32'hC7D1_0000);
    send_reading('{16'd27898, 24'h5D2300}, 1'b0, '0);
    drain();
    // Temperature divisor zero with nonzero gain: ut=ac6 gives x1=0, md=0
    write_reg(REG_COEF4, 32'h8000_0000);
    send_reading('{16'd23153, 24'h123456}, 1'b1, '{16'd0, 32'd0, ERR_TDIV});
    drain();
    // Extreme coefficients, most negative mc
    write_reg(REG_COEF0, 32'h8000_7FFF);
    write_reg(REG_COEF1, 32'h7FFF_FFFF);
    write_reg(REG_COEF2, 32'hFFFF_0000);
    write_reg(REG_COEF3, 32'h8000_7FFF);
    write_reg(REG_COEF4, 32'h8000_FFFF);
    send_reading('{16'hFFFF, 24'hFFFFFF}, 1'b0, '0);
    send_reading('{16'h0000, 24'h000000}, 1'b0, '0);
    drain();

    // Random phases: typical calibrations with noise alternate with fully random ones
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0) begin
        load_typical();
        write_reg(REG_COEF2, {16'd32757 + 16'($urandom_range(0, 255)) - 16'd128,
                              16'd23153 + 16'($urandom_range(0, 511))});
      end else begin
        for (int k = 0; k <= 4; k++) write_reg(k[2:0], $urandom);
      end
      write_reg(REG_OSS, $urandom_range(0, 3));
      if (ph == 5) quiet = 1'b1;
      for (int n = 0; n < 120; n++) begin
        if (ph % 2 == 0 && $urandom_range(0, 3) != 0) begin
          rd.raw_temp = 16'($urandom_range(20000, 36000));
          rd.raw_press = 24'($urandom_range(20000, 45000) << 8) | 24'($urandom_range(0, 255));
        end else begin
          rd.raw_temp = 16'($urandom);
          rd.raw_press = 24'($urandom);
        end
        send_reading(rd, 1'b0, '0);
      end
      // Hold off until every result is back
      drain();
    end

    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[barometric_sensor_compensation.f]
src/bsc_pkg.sv
src/bsc_div.sv
src/barometric_sensor_compensation.sv
test/barometric_sensor_compensation_tb.sv
